>>> rtl/core/assert_macros.svh
// Assertion macros shared by the solver RTL.
// Each macro expects i_clk and i_rst_n in the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while reset is held.
`define ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, off while reset is held.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/owss_pkg.sv
// Shared types, constants and arithmetic helpers for the omni wheel speed solver.
// No dependencies; used by owss_cordic, owss_wheel and the top level.
`default_nettype none

package owss_pkg;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] REG_ROTATE_GAIN = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SPEED_GAIN  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ARM_X       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ARM_Y       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_RPM_RATIO   = 3'd4;

    localparam logic [15:0] ROTATE_GAIN_RST = 16'd2048;
    localparam logic [15:0] SPEED_GAIN_RST  = 16'd6144;

    // Payload beats
    typedef struct packed {
        logic signed [15:0] cmd_vx;
        logic signed [15:0] cmd_vy;
        logic signed [15:0] cmd_spin;
        logic        [15:0] heading;
    } t_cmd;

    typedef struct packed {
        logic signed [15:0] target_front_left;
        logic signed [15:0] target_back_left;
        logic signed [15:0] target_front_right;
        logic signed [15:0] target_back_right;
        logic               clipped;
    } t_result;

    // CORDIC
    localparam int CORDIC_STEPS = 16;
    localparam int CORDIC_PAIRS = CORDIC_STEPS / 2;
    localparam logic signed [31:0] CORDIC_X0 = 32'sd652032874;

    localparam logic signed [31:0] ATAN_TAB [CORDIC_STEPS] = '{
        32'sh2000_0000, 32'sh12E4_051E, 32'sh09FB_385B, 32'sh0511_11D4,
        32'sh028B_0D43, 32'sh0145_D7E1, 32'sh00A2_F61E, 32'sh0051_7C55,
        32'sh0028_BE53, 32'sh0014_5F2F, 32'sh000A_2F98, 32'sh0005_17CC,
        32'sh0002_8BE6, 32'sh0001_45F3, 32'sh0000_A2FA, 32'sh0000_517D
    };

    localparam logic [1:0] QUAD_0   = 2'd0;
    localparam logic [1:0] QUAD_90  = 2'd1;
    localparam logic [1:0] QUAD_180 = 2'd2;
    localparam logic [1:0] QUAD_270 = 2'd3;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
    } t_cstate;

    typedef struct packed {
        logic signed [15:0] cos_val;
        logic signed [15:0] sin_val;
    } t_trig;

    typedef struct packed {
        logic signed [15:0] val;
        logic               clip;
    } t_sat;

    // Pipeline layout: stage 0 entry, CORDIC pairs, trig out, then rotation,
    // chassis sums, lever sums, ten wheel stages.
    localparam int TRIG_STAGE   = CORDIC_PAIRS + 1;
    localparam int WHEEL_STAGES = 10;
    localparam int PIPE_DEPTH   = TRIG_STAGE + 3 + WHEEL_STAGES + 1;
    localparam int NUM_WHEELS   = 4;
    localparam int CHASSIS_SHIFT = 10;

    localparam int PRD_W = 32;  // vx * cos
    localparam int CH_W  = 33;  // chassis velocity, Q.14
    localparam int CHW_W = 33;  // spin * rotate_gain
    localparam int LEV_W = 49;  // spin lever term
    localparam int P_W   = 50;  // lever-corrected velocity, Q.24

    // Wheel mounting angles in degrees
    localparam int FRONT_LEFT_ANGLE  = 45;
    localparam int BACK_LEFT_ANGLE   = 135;
    localparam int FRONT_RIGHT_ANGLE = -45;
    localparam int BACK_RIGHT_ANGLE  = -135;

    // One rotation step; i is fixed at each place of use.
    function automatic t_cstate cordic_step(input t_cstate s, input logic [3:0] i);
        logic signed [31:0] dx;
        logic signed [31:0] dy;
        t_cstate r;
        dx = s.y >>> i;
        dy = s.x >>> i;
        r  = s;
        if (!s.z[31]) begin
            r.x = s.x - dx;
            r.y = s.y + dy;
            r.z = s.z - ATAN_TAB[i];
        end else begin
            r.x = s.x + dx;
            r.y = s.y - dy;
            r.z = s.z + ATAN_TAB[i];
        end
        return r;
    endfunction

    // Round Q2.30 half up to Q2.14, then undo the quadrant fold.
    function automatic t_trig trig_map(input t_cstate s, input logic [1:0] q);
        logic signed [31:0] cx;
        logic signed [31:0] sy;
        logic signed [15:0] c;
        logic signed [15:0] sn;
        t_trig r;
        cx = s.x + 32'sd32768;
        sy = s.y + 32'sd32768;
        c  = cx[31:16];
        sn = sy[31:16];
        case (q)
            QUAD_0:   begin r.cos_val = c;   r.sin_val = sn;  end
            QUAD_90:  begin r.cos_val = -sn; r.sin_val = c;   end
            QUAD_180: begin r.cos_val = -c;  r.sin_val = -sn; end
            default:  begin r.cos_val = sn;  r.sin_val = -c;  end
        endcase
        return r;
    endfunction

    // Elaboration-time sine and cosine for the fixed wheel angles.
    function automatic t_trig cordic_sincos(input logic [31:0] a);
        logic [31:0] sum;
        logic [1:0]  q;
        logic [31:0] t;
        t_cstate s;
        sum = a + 32'h2000_0000;
        q   = sum[31:30];
        t   = a - {q, 30'd0};
        s.x = CORDIC_X0;
        s.y = 32'sd0;
        s.z = $signed(t);
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            s = cordic_step(s, 4'(i));
        end
        return trig_map(s, q);
    endfunction

    function automatic logic [31:0] deg_to_bam(input int deg);
        int          d;
        logic [63:0] num;
        d = deg % 360;
        if (d < 0) begin
            d = d + 360;
        end
        num = (64'(d) << 32) + 64'd180;
        return 32'(num / 64'd360);
    endfunction

    localparam t_trig WHEEL_TRIG [NUM_WHEELS] = '{
        cordic_sincos(deg_to_bam(FRONT_LEFT_ANGLE)),
        cordic_sincos(deg_to_bam(BACK_LEFT_ANGLE)),
        cordic_sincos(deg_to_bam(FRONT_RIGHT_ANGLE)),
        cordic_sincos(deg_to_bam(BACK_RIGHT_ANGLE))
    };

    function automatic t_sat sat16(input logic signed [37:0] v);
        t_sat r;
        if (v > 38'sd32767) begin
            r.val  = 16'sd32767;
            r.clip = 1'b1;
        end else if (v < -38'sd32768) begin
            r.val  = -16'sd32768;
            r.clip = 1'b1;
        end else begin
            r.val  = v[15:0];
            r.clip = 1'b0;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/owss_cordic.sv
// Pipelined heading sine/cosine: quadrant fold, eight stages of two
// CORDIC rotations, round and unfold. Depends on owss_pkg.
`default_nettype none

module owss_cordic
    import owss_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_en,
    input  wire logic [15:0] i_heading,
    output t_trig            o_trig
);

    t_cstate    r_st [0:CORDIC_PAIRS];
    logic [1:0] r_q  [0:CORDIC_PAIRS];
    t_trig      r_trig;

    logic [15:0] hd_off;
    logic [1:0]  q0;
    logic [15:0] z16;

    // Fold into [-45,45) degrees plus a quadrant
    assign hd_off = i_heading + 16'h2000;
    assign q0     = hd_off[15:14];
    assign z16    = i_heading - {q0, 14'd0};

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_st[0].x <= CORDIC_X0;
            r_st[0].y <= 32'sd0;
            r_st[0].z <= $signed({z16, 16'd0});
            r_q[0]    <= q0;
            r_trig    <= trig_map(r_st[CORDIC_PAIRS], r_q[CORDIC_PAIRS]);
        end
    end

    for (genvar k = 1; k <= CORDIC_PAIRS; k++) begin : g_pair
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_st[k] <= cordic_step(cordic_step(r_st[k-1], 4'(2*k-2)), 4'(2*k-1));
                r_q[k]  <= r_q[k-1];
            end
        end
    end

    assign o_trig = r_trig;

endmodule

`default_nettype wire

>>> rtl/core/owss_wheel.sv
// One wheel lane: projection onto the mounting direction, truncated, then rpm
// scaling and speed gain, each truncated and saturated. Ten stages. Depends on owss_pkg.
`default_nettype none

module owss_wheel
    import owss_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_en,
    input  wire logic signed [P_W-1:0] i_px,
    input  wire logic signed [P_W-1:0] i_py,
    input  t_trig                      i_trig,
    input  wire logic [23:0]           i_rpm_ratio,
    input  wire logic [15:0]           i_speed_gain,
    output logic signed [15:0]         o_target,
    output logic                       o_clip
);

    logic signed [63:0] r_pc;
    logic signed [63:0] r_ps;
    logic signed [63:0] r_w;
    logic signed [39:0] r_w14;
    logic signed [44:0] r_ph;
    logic        [43:0] r_pl;
    logic signed [63:0] r_prod;
    logic signed [37:0] r_q26;
    logic signed [15:0] r_rpm;
    logic               r_clip_rpm;
    logic signed [32:0] r_t;
    logic               r_clip_t;
    logic signed [20:0] r_t12;
    logic               r_clip_q;
    logic signed [15:0] r_target;
    logic               r_clip;

    logic signed [63:0] w_biased;
    logic signed [63:0] p_biased;
    logic signed [32:0] t_biased;
    logic signed [19:0] w_hi;
    logic        [19:0] w_lo;
    t_sat               rpm_sat;
    t_sat               tgt_sat;

    // Bias negatives so the arithmetic shift truncates toward zero
    assign w_biased = r_w + 64'($signed({1'b0, {24{r_w[63]}}}));
    assign p_biased = r_prod + 64'($signed({1'b0, {26{r_prod[63]}}}));
    assign t_biased = r_t + 33'($signed({1'b0, {12{r_t[32]}}}));

    // Split the 40-bit wheel speed so each product stays narrow
    assign w_hi = r_w14[39:20];
    assign w_lo = r_w14[19:0];

    assign rpm_sat = sat16(r_q26);
    assign tgt_sat = sat16(38'(r_t12));

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pc       <= 64'(i_px) * 64'(i_trig.cos_val);
            r_ps       <= 64'(i_py) * 64'(i_trig.sin_val);
            r_w        <= r_pc + r_ps;
            r_w14      <= w_biased[63:24];
            r_ph       <= 45'(w_hi) * 45'($signed({1'b0, i_rpm_ratio}));
            r_pl       <= 44'(w_lo) * 44'(i_rpm_ratio);
            r_prod     <= (64'(r_ph) <<< 20) + $signed(64'(r_pl));
            r_q26      <= p_biased[63:26];
            r_rpm      <= rpm_sat.val;
            r_clip_rpm <= rpm_sat.clip;
            r_t        <= 33'(r_rpm) * 33'($signed({1'b0, i_speed_gain}));
            r_clip_t   <= r_clip_rpm;
            r_t12      <= t_biased[32:12];
            r_clip_q   <= r_clip_t;
            r_target   <= tgt_sat.val;
            r_clip     <= r_clip_q | tgt_sat.clip;
        end
    end

    assign o_target = r_target;
    assign o_clip   = r_clip;

endmodule

`default_nettype wire

>>> rtl/core/omni_wheel_speed_solver.sv
// Omni wheel speed solver top level: command pipeline, four wheel lanes and
// a two-entry result buffer. Depends on owss_pkg, owss_cordic, owss_wheel, assert_macros.svh.
//
// Takes one command beat per cycle while o_stall is low and returns one result
// beat per command, in order. The pipeline depth comes from the sixteen-step
// heading CORDIC (two rotations per stage) followed by the rotation, lever
// and per-wheel multiply, truncate and saturate chain. Results wait in a
// two-entry buffer, so commands keep flowing while one result is held;
// o_stall rises only when both entries are taken, and the whole pipeline
// then holds. Registers are written through i_cfg_we/i_cfg_index/i_cfg_data
// and act on every beat after the write, so write them only while nothing
// is in flight.
`default_nettype none
`include "assert_macros.svh"

module omni_wheel_speed_solver
    import owss_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                  i_valid,
    output logic                       o_stall,
    input  t_cmd                       i_cmd,
    output logic                       o_valid,
    input  wire logic                  i_stall,
    output t_result                    o_result
);

    localparam int LAST = PIPE_DEPTH - 1;

    // Configuration
    logic        [15:0] r_rotate_gain;
    logic        [15:0] r_speed_gain;
    logic signed [15:0] r_arm_x;
    logic signed [15:0] r_arm_y;
    logic        [23:0] r_rpm_ratio;

    // Pipeline control
    logic [LAST:0] r_v;
    logic          en;
    logic          in_acc;
    logic          push;
    logic          pop;

    // Front stages
    logic signed [15:0]      r_vx  [0:TRIG_STAGE];
    logic signed [15:0]      r_vy  [0:TRIG_STAGE];
    logic signed [CHW_W-1:0] r_chw [0:TRIG_STAGE-1];
    logic signed [LEV_W-1:0] r_ax9;
    logic signed [LEV_W-1:0] r_ay9;
    logic signed [LEV_W-1:0] r_ax10;
    logic signed [LEV_W-1:0] r_ay10;
    logic signed [LEV_W-1:0] r_ax11;
    logic signed [LEV_W-1:0] r_ay11;
    logic signed [PRD_W-1:0] r_p_xc;
    logic signed [PRD_W-1:0] r_p_ys;
    logic signed [PRD_W-1:0] r_p_xs;
    logic signed [PRD_W-1:0] r_p_yc;
    logic signed [CH_W-1:0]  r_chx;
    logic signed [CH_W-1:0]  r_chy;
    logic signed [P_W-1:0]   r_px;
    logic signed [P_W-1:0]   r_py;
    t_trig                   trig;

    // Lanes and result buffer
    logic signed [15:0]    lane_target [NUM_WHEELS];
    logic [NUM_WHEELS-1:0] lane_clip;
    t_result               lane_res;
    t_result               r_buf [0:1];
    logic                  r_wr_ptr;
    logic                  r_rd_ptr;
    logic [1:0]            r_cnt;
    logic [1:0]            n_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rotate_gain <= ROTATE_GAIN_RST;
            r_speed_gain  <= SPEED_GAIN_RST;
            r_arm_x       <= 16'sd0;
            r_arm_y       <= 16'sd0;
            r_rpm_ratio   <= 24'd0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_ROTATE_GAIN: r_rotate_gain <= i_cfg_data[15:0];
                REG_SPEED_GAIN:  r_speed_gain  <= i_cfg_data[15:0];
                REG_ARM_X:       r_arm_x       <= $signed(i_cfg_data[15:0]);
                REG_ARM_Y:       r_arm_y       <= $signed(i_cfg_data[15:0]);
                REG_RPM_RATIO:   r_rpm_ratio   <= i_cfg_data[23:0];
                default: ;
            endcase
        end
    end

    // Advance the whole pipeline whenever the buffer has room
    assign en      = (r_cnt != 2'd2);
    assign o_stall = !en;
    assign in_acc  = i_valid && en;
    assign push    = en && r_v[LAST];
    assign pop     = o_valid && !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (en) begin
            r_v <= {r_v[LAST-1:0], i_valid};
        end
    end

    owss_cordic u_cordic (
        .i_clk     (i_clk),
        .i_en      (en),
        .i_heading (i_cmd.heading),
        .o_trig    (trig)
    );

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_vx[0]  <= i_cmd.cmd_vx;
            r_vy[0]  <= i_cmd.cmd_vy;
            r_chw[0] <= CHW_W'(i_cmd.cmd_spin) * CHW_W'($signed({1'b0, r_rotate_gain}));
            for (int k = 1; k <= TRIG_STAGE; k++) begin
                r_vx[k] <= r_vx[k-1];
                r_vy[k] <= r_vy[k-1];
            end
            for (int k = 1; k < TRIG_STAGE; k++) begin
                r_chw[k] <= r_chw[k-1];
            end
            // Spin lever terms, ready alongside the heading trig
            r_ax9  <= LEV_W'(r_chw[TRIG_STAGE-1]) * LEV_W'(r_arm_x);
            r_ay9  <= LEV_W'(r_chw[TRIG_STAGE-1]) * LEV_W'(r_arm_y);
            r_p_xc <= PRD_W'(r_vx[TRIG_STAGE]) * PRD_W'(trig.cos_val);
            r_p_ys <= PRD_W'(r_vy[TRIG_STAGE]) * PRD_W'(trig.sin_val);
            r_p_xs <= PRD_W'(r_vx[TRIG_STAGE]) * PRD_W'(trig.sin_val);
            r_p_yc <= PRD_W'(r_vy[TRIG_STAGE]) * PRD_W'(trig.cos_val);
            r_ax10 <= r_ax9;
            r_ay10 <= r_ay9;
            r_chx  <= CH_W'(r_p_xc) - CH_W'(r_p_ys);
            r_chy  <= CH_W'(r_p_xs) + CH_W'(r_p_yc);
            r_ax11 <= r_ax10;
            r_ay11 <= r_ay10;
            r_px   <= (P_W'(r_chx) <<< CHASSIS_SHIFT) - P_W'(r_ay11);
            r_py   <= (P_W'(r_chy) <<< CHASSIS_SHIFT) + P_W'(r_ax11);
        end
    end

    for (genvar g = 0; g < NUM_WHEELS; g++) begin : g_wheel
        owss_wheel u_wheel (
            .i_clk        (i_clk),
            .i_en         (en),
            .i_px         (r_px),
            .i_py         (r_py),
            .i_trig       (WHEEL_TRIG[g]),
            .i_rpm_ratio  (r_rpm_ratio),
            .i_speed_gain (r_speed_gain),
            .o_target     (lane_target[g]),
            .o_clip       (lane_clip[g])
        );
    end

    always_comb begin
        lane_res.target_front_left  = lane_target[0];
        lane_res.target_back_left   = lane_target[1];
        lane_res.target_front_right = lane_target[2];
        lane_res.target_back_right  = lane_target[3];
        lane_res.clipped            = |lane_clip;
    end

    assign n_cnt = r_cnt + 2'(push) - 2'(pop);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_cnt    <= 2'd0;
        end else begin
            if (push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_buf[r_wr_ptr] <= lane_res;
        end
    end

    assign o_valid  = (r_cnt != 2'd0);
    assign o_result = r_buf[r_rd_ptr];

    // Beats in flight change only by what is taken and what is delivered
    `ASSERT_NEXT(a_inflight, 1'b1, ($countones(r_v) + int'(r_cnt)) == ($past($countones(r_v)) + int'($past(r_cnt)) + int'($past(in_acc)) - int'($past(pop))), "in-flight beat count drifted")
    // A held pipeline keeps every valid bit in place
    `ASSERT_NEXT(a_hold, o_stall, $stable(r_v), "pipeline moved while held")
    // Never push into a full result buffer
    `ASSERT_IMPLY(a_no_overflow, push, r_cnt != 2'd2, "result buffer overflow")

endmodule

`default_nettype wire
